FILE: design/kvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvc_pkg
// Shared types and constants of the FIFO-replacement key-value cache.
// ----------------------------------------------------------------------------
package kvc_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 7;
    localparam int ENTRIES_DEF = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CAP_W-1:0]        CAP_RESET  = 7'd64;
    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    // opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] put_value;
    } t_in_beat;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
    } t_out_beat;

    // classified command as it travels through the queue
    typedef struct packed {
        logic                    is_put;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

    typedef struct packed {
        logic             valid;
        logic [CAP_W-1:0] data;
    } t_cfg_wr;

endpackage : kvc_pkg
`default_nettype wire

FILE: design/kvc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvc_front
// Input stage: registers the incoming beat, decodes it and pushes it on.
// ----------------------------------------------------------------------------
module kvc_front
    import kvc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_beat,
    input  wire t_q_status i_q,
    output logic           o_push,
    output t_cmd           o_cmd,
    output logic           o_holding
);

    logic     r_hold_valid;
    logic     n_hold_valid;
    t_in_beat r_hold;
    logic     accept;

    assign o_in_stall = r_hold_valid && i_q.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_hold_valid && !i_q.full;
    assign o_holding  = r_hold_valid;

    always_comb begin
        o_cmd.is_put = (r_hold.opcode == OP_PUT);
        o_cmd.key    = r_hold.key;
        o_cmd.value  = r_hold.put_value;
    end

    always_comb begin
        n_hold_valid = r_hold_valid;
        if (accept) begin
            n_hold_valid = 1'b1;
        end else if (o_push) begin
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold <= i_in_beat;
        end
    end

endmodule : kvc_front
`default_nettype wire

FILE: design/kvc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvc_queue
// Short command queue between the front and the search engine.
// ----------------------------------------------------------------------------
module kvc_queue
    import kvc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_q_status o_status,
    output t_cmd      o_cmd
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_cmd           r_slot [QUEUE_DEPTH];
    logic [QAW:0]   r_wr_ptr;
    logic [QAW:0]   r_rd_ptr;
    logic [QAW:0]   n_wr_ptr;
    logic [QAW:0]   n_rd_ptr;

    assign o_status.full      = (r_wr_ptr[QAW] != r_rd_ptr[QAW]) &&
                                (r_wr_ptr[QAW-1:0] == r_rd_ptr[QAW-1:0]);
    assign o_status.not_empty = (r_wr_ptr != r_rd_ptr);
    assign o_cmd              = r_slot[r_rd_ptr[QAW-1:0]];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + (QAW+1)'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr[QAW-1:0]] <= i_cmd;
        end
    end

endmodule : kvc_queue
`default_nettype wire

FILE: design/kvc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvc_back
// Search engine: scans the key memory one slot a cycle, then updates the
// store and loads the result register.
// ----------------------------------------------------------------------------
module kvc_back
    import kvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg_wr   i_cfg,
    input  wire t_q_status i_q,
    input  wire t_cmd      i_q_cmd,
    output logic           o_q_pop,
    output logic           o_idle,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_beat
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [KEY_W-1:0]        r_mem_key [ENTRIES];
    logic signed [VAL_W-1:0] r_mem_val [ENTRIES];

    logic [1:0]              r_state, n_state;
    logic [CAP_W-1:0]        r_capacity, n_capacity;
    logic [CW-1:0]           r_fill, n_fill;
    logic [CW-1:0]           r_ptr, n_ptr;
    logic [CW-1:0]           r_idx, n_idx;
    t_cmd                    r_cmd, n_cmd;
    logic                    r_q_vld, n_q_vld;
    logic                    r_q_last, n_q_last;
    logic [IW-1:0]           r_q_idx, n_q_idx;
    logic [KEY_W-1:0]        r_key_q;
    logic signed [VAL_W-1:0] r_val_q;
    logic                    r_found, n_found;
    logic [IW-1:0]           r_where, n_where;
    logic signed [VAL_W-1:0] r_hit_val, n_hit_val;
    logic                    r_out_valid, n_out_valid;
    t_out_beat               r_out, n_out;

    logic [31:0]             cap_ext;
    logic [31:0]             eff_wide;
    logic [CW-1:0]           eff_cap;
    logic [CW-1:0]           live;
    logic [CW-1:0]           slot;
    logic [CW-1:0]           slot_inc;
    logic [CW-1:0]           slot_next;
    logic                    out_free;
    logic                    issue;
    logic                    match;
    logic                    wr_key_en;
    logic                    wr_val_en;
    logic [IW-1:0]           wr_addr;

    // clamp capacity into 1..ENTRIES
    always_comb begin
        cap_ext = 32'(r_capacity);
        if (cap_ext == 32'd0) begin
            eff_wide = 32'd1;
        end else if (cap_ext > 32'(ENTRIES)) begin
            eff_wide = 32'(ENTRIES);
        end else begin
            eff_wide = cap_ext;
        end
        eff_cap = eff_wide[CW-1:0];
    end

    assign live      = (r_fill > eff_cap) ? eff_cap : r_fill;
    assign slot      = (r_ptr >= eff_cap) ? '0 : r_ptr;
    assign slot_inc  = slot + CW'(1);
    assign slot_next = (slot_inc >= eff_cap) ? '0 : slot_inc;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign issue     = (r_state == S_SCAN) && (r_idx < live);
    assign match     = r_q_vld && (r_key_q == r_cmd.key);

    assign o_idle      = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    always_comb begin
        n_state     = r_state;
        n_capacity  = r_capacity;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_q_vld     = r_q_vld;
        n_q_last    = r_q_last;
        n_q_idx     = r_q_idx;
        n_found     = r_found;
        n_where     = r_where;
        n_hit_val   = r_hit_val;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        wr_key_en   = 1'b0;
        wr_val_en   = 1'b0;
        wr_addr     = r_where;

        // drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_q.not_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = '0;
                    n_q_vld = 1'b0;
                    n_found = 1'b0;
                    n_state = (live == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                n_q_vld = issue;
                if (issue) begin
                    n_idx    = r_idx + CW'(1);
                    n_q_idx  = r_idx[IW-1:0];
                    n_q_last = ((r_idx + CW'(1)) == live);
                end
                if (match) begin
                    n_found   = 1'b1;
                    n_where   = r_q_idx;
                    n_hit_val = r_val_q;
                    n_q_vld   = 1'b0;
                    n_state   = S_FINISH;
                end else if (r_q_vld && r_q_last) begin
                    n_q_vld = 1'b0;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                    n_out.hit        = r_found;
                    n_out.read_value = '0;
                    n_out.evicted    = 1'b0;
                    if (!r_cmd.is_put) begin
                        n_out.read_value = r_found ? r_hit_val : MISS_VALUE;
                    end else if (r_found) begin
                        // update in place, age unchanged
                        wr_val_en = 1'b1;
                        wr_addr   = r_where;
                    end else begin
                        wr_key_en = 1'b1;
                        wr_val_en = 1'b1;
                        wr_addr   = slot[IW-1:0];
                        n_ptr     = slot_next;
                        if (live >= eff_cap) begin
                            n_out.evicted = 1'b1;
                            n_fill        = live;
                        end else begin
                            n_fill = live + CW'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // capacity write empties the store
        if (i_cfg.valid) begin
            n_capacity = i_cfg.data;
            n_fill     = '0;
            n_ptr      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= CAP_RESET;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_q_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_capacity  <= n_capacity;
            r_fill      <= n_fill;
            r_ptr       <= n_ptr;
            r_q_vld     <= n_q_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmd     <= n_cmd;
        r_q_last  <= n_q_last;
        r_q_idx   <= n_q_idx;
        r_found   <= n_found;
        r_where   <= n_where;
        r_hit_val <= n_hit_val;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_key_q <= r_mem_key[r_idx[IW-1:0]];
            r_val_q <= r_mem_val[r_idx[IW-1:0]];
        end
        if (wr_key_en) begin
            r_mem_key[wr_addr] <= r_cmd.key;
        end
        if (wr_val_en) begin
            r_mem_val[wr_addr] <= r_cmd.value;
        end
    end

`ifndef SYNTHESIS
    a_fill_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= eff_cap)
        else $error("fill count exceeds capacity");

    a_ptr_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr < eff_cap)
        else $error("insert pointer outside capacity");

    a_cmp_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_vld |-> (CW'(r_q_idx) < live))
        else $error("compare of a slot that is not live");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.evicted) |-> !r_out.hit)
        else $error("eviction reported on a hit");
`endif

endmodule : kvc_back
`default_nettype wire

FILE: design/fifo_replacement_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_replacement_key_value_cache
// Fully associative key-value store with first-in-first-out replacement.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload          direction
//   -------   ------------------   --------------   ---------
//   in        i_in_valid/o_in_stall   i_in_beat     get/put beat into block
//   out       o_out_valid/i_out_stall o_out_beat    one result beat per input
//   cfg       i_cfg_valid/o_cfg_ready i_cfg_data    capacity register write
//
// A beat holds the search engine for a scan of all live entries on a miss (no
// scan on an empty store) or up to slot k on a hit in slot k, live being the stored
// entries; the scan reads the key memory read port one slot per cycle.
// The front register and the two-deep queue take up to three beats ahead of
// the engine, so the input side keeps moving while a result waits on a stall.
// Reset is synchronous and empties the store; the memories keep no reset.
// ----------------------------------------------------------------------------
module fifo_replacement_key_value_cache
    import kvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_beat         i_in_beat,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_beat             o_out_beat,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CAP_W-1:0] i_cfg_data
);

    t_q_status q_status;
    t_cmd      front_cmd;
    t_cmd      queue_cmd;
    t_cfg_wr   cfg_wr;
    logic      push;
    logic      pop;
    logic      front_holding;
    logic      back_idle;

    // take config only with no beat anywhere in flight
    assign o_cfg_ready  = back_idle && !q_status.not_empty && !front_holding;
    assign cfg_wr.valid = i_cfg_valid && o_cfg_ready;
    assign cfg_wr.data  = i_cfg_data;

    // accept and decode
    kvc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .i_q        (q_status),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .o_holding  (front_holding)
    );

    // decouple front from the search engine
    kvc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_status (q_status),
        .o_cmd    (queue_cmd)
    );

    // scan, update store, hold result
    kvc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_q         (q_status),
        .i_q_cmd     (queue_cmd),
        .o_q_pop     (pop),
        .o_idle      (back_idle),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule : fifo_replacement_key_value_cache
`default_nettype wire
